// ===== rtl/core/rgbcsp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the rgb:R/G/B colour spec parser.
// No dependencies; every other file of the block imports this package.
package rgbcsp_pkg;

    localparam int TARGET_DIGITS_DEF = 2;
    localparam int ACC_BITS_DEF      = 32;
    localparam int QUEUE_DEPTH       = 2;

    localparam int CNT_BITS = 4;
    localparam int CH_BITS  = 8;
    localparam int COMP_BITS = 8;
    localparam int STATUS_BITS = 3;

    localparam logic [STATUS_BITS-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_PREFIX = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_RED    = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_GREEN  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_BLUE   = 3'd4;

    localparam logic [CH_BITS-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_BITS-1:0] CH_SLASH = 8'h2F;
    localparam logic [CH_BITS-1:0] CH_R     = 8'h72;
    localparam logic [CH_BITS-1:0] CH_G     = 8'h67;
    localparam logic [CH_BITS-1:0] CH_B     = 8'h62;
    localparam logic [CH_BITS-1:0] CH_COLON = 8'h3A;

    // One classified character as it travels from front to back.
    typedef struct packed {
        logic                is_hex;
        logic [3:0]          digit;
        logic                is_slash;
        logic                is_nul;
        logic [3:0]          pfx_hit;   // bit i: matches prefix character i
    } t_token;

endpackage

// ===== rtl/core/rgbcsp_front.sv =====
`timescale 1ns / 1ps
// Front end: classifies each incoming character into a token.
// Depends on rgbcsp_pkg.
module rgbcsp_front
    import rgbcsp_pkg::*;
(
    input  logic [CH_BITS-1:0] i_ch,
    output t_token             o_tok
);

    logic       n_hex;
    logic [3:0] n_digit;

    always_comb begin
        n_hex   = 1'b1;
        n_digit = 4'd0;
        if (i_ch >= 8'h30 && i_ch <= 8'h39) begin
            n_digit = 4'(i_ch - 8'h30);
        end else if (i_ch >= 8'h61 && i_ch <= 8'h66) begin
            n_digit = 4'(i_ch - 8'h57);
        end else if (i_ch >= 8'h41 && i_ch <= 8'h46) begin
            n_digit = 4'(i_ch - 8'h37);
        end else begin
            n_hex = 1'b0;
        end
    end

    assign o_tok.is_hex     = n_hex;
    assign o_tok.digit      = n_digit;
    assign o_tok.is_slash   = (i_ch == CH_SLASH);
    assign o_tok.is_nul     = (i_ch == CH_NUL);
    assign o_tok.pfx_hit[0] = (i_ch == CH_R);
    assign o_tok.pfx_hit[1] = (i_ch == CH_G);
    assign o_tok.pfx_hit[2] = (i_ch == CH_B);
    assign o_tok.pfx_hit[3] = (i_ch == CH_COLON);

endmodule

// ===== rtl/core/rgbcsp_queue.sv =====
`timescale 1ns / 1ps
// Short token FIFO between the classifier and the parser.
// Depends on rgbcsp_pkg.
module rgbcsp_queue
    import rgbcsp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_tok,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_avail,
    output t_token o_tok
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(QUEUE_DEPTH - 1);

    t_token              r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr, r_rd;
    logic [CNT_W-1:0]    r_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/rgbcsp_back.sv =====
`timescale 1ns / 1ps
// Back end: parse state machine, accumulators, scaling and result register.
// Depends on rgbcsp_pkg.
module rgbcsp_back
    import rgbcsp_pkg::*;
#(
    parameter int TARGET_DIGITS = TARGET_DIGITS_DEF,
    parameter int ACC_BITS      = ACC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_avail,
    input  t_token                 i_tok,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [STATUS_BITS-1:0] o_status,
    output logic [COMP_BITS-1:0]   o_red,
    output logic [COMP_BITS-1:0]   o_green,
    output logic [COMP_BITS-1:0]   o_blue
);

    localparam logic [CNT_BITS-1:0] TGT = CNT_BITS'(TARGET_DIGITS);

    typedef enum logic [7:0] {
        PH_P0      = 8'b0000_0001,
        PH_P1      = 8'b0000_0010,
        PH_P2      = 8'b0000_0100,
        PH_P3      = 8'b0000_1000,
        PH_RED     = 8'b0001_0000,
        PH_GREEN   = 8'b0010_0000,
        PH_BLUE    = 8'b0100_0000,
        PH_DISCARD = 8'b1000_0000
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [ACC_BITS-1:0]   r_acc_r, r_acc_g, r_acc_b;
    logic [CNT_BITS-1:0]   r_cnt_r, r_cnt_g, r_cnt_b;
    logic                  r_valid;
    logic [STATUS_BITS-1:0] r_status, n_status;
    logic [COMP_BITS-1:0]  r_red, r_green, r_blue;

    logic                  n_emit, n_clear;
    logic [2:0]            n_add;     // digit goes to red, green, blue
    logic [CNT_BITS-1:0]   maxd, diff;
    logic [5:0]            sh;
    logic                  up;
    logic [ACC_BITS-1:0]   sc_r, sc_g, sc_b;

    assign o_pop = i_avail && (!r_valid || !i_stall);

    // Parse step for the token at the head of the queue.
    always_comb begin
        n_phase  = r_phase;
        n_emit   = 1'b0;
        n_status = ST_OK;
        n_clear  = 1'b0;
        n_add    = 3'b000;
        unique case (r_phase)
            PH_P0, PH_P1, PH_P2, PH_P3: begin
                if (!(|(i_tok.pfx_hit & r_phase[3:0]))) begin
                    n_emit   = 1'b1;
                    n_status = ST_PREFIX;
                    n_phase  = i_tok.is_nul ? PH_P0 : PH_DISCARD;
                end else begin
                    priority case (1'b1)
                        r_phase[0]: n_phase = PH_P1;
                        r_phase[1]: n_phase = PH_P2;
                        r_phase[2]: n_phase = PH_P3;
                        default: begin
                            n_phase = PH_RED;
                            n_clear = 1'b1;
                        end
                    endcase
                end
            end
            PH_RED: begin
                if (i_tok.is_hex) begin
                    n_add[0] = 1'b1;
                end else if (i_tok.is_slash) begin
                    n_phase = PH_GREEN;
                end else begin
                    n_emit   = 1'b1;
                    n_status = ST_RED;
                    n_phase  = i_tok.is_nul ? PH_P0 : PH_DISCARD;
                end
            end
            PH_GREEN: begin
                if (i_tok.is_hex) begin
                    n_add[1] = 1'b1;
                end else if (i_tok.is_slash) begin
                    n_phase = PH_BLUE;
                end else begin
                    n_emit   = 1'b1;
                    n_status = ST_GREEN;
                    n_phase  = i_tok.is_nul ? PH_P0 : PH_DISCARD;
                end
            end
            PH_BLUE: begin
                if (i_tok.is_hex) begin
                    n_add[2] = 1'b1;
                end else if (i_tok.is_nul) begin
                    n_emit  = 1'b1;
                    n_phase = PH_P0;
                end else begin
                    n_emit   = 1'b1;
                    n_status = ST_BLUE;
                    n_phase  = PH_DISCARD;
                end
            end
            PH_DISCARD: begin
                if (i_tok.is_nul) begin
                    n_phase = PH_P0;
                end
            end
            default: begin
                n_phase = PH_P0;
            end
        endcase
    end

    // Scale all components by the longest field; shifts past the width give zero.
    always_comb begin
        maxd = r_cnt_r;
        if (r_cnt_g > maxd) maxd = r_cnt_g;
        if (r_cnt_b > maxd) maxd = r_cnt_b;
        up   = (maxd < TGT);
        diff = up ? (TGT - maxd) : (maxd - TGT);
        sh   = {diff, 2'b00};
        sc_r = up ? (r_acc_r << sh) : (r_acc_r >> sh);
        sc_g = up ? (r_acc_g << sh) : (r_acc_g >> sh);
        sc_b = up ? (r_acc_b << sh) : (r_acc_b >> sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_P0;
            r_valid <= 1'b0;
            r_cnt_r <= '0;
            r_cnt_g <= '0;
            r_cnt_b <= '0;
            r_acc_r <= '0;
            r_acc_g <= '0;
            r_acc_b <= '0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                if (n_clear) begin
                    r_cnt_r <= '0;
                    r_cnt_g <= '0;
                    r_cnt_b <= '0;
                    r_acc_r <= '0;
                    r_acc_g <= '0;
                    r_acc_b <= '0;
                end
                if (n_add[0]) begin
                    r_acc_r <= {r_acc_r[ACC_BITS-5:0], i_tok.digit};
                    if (r_cnt_r != '1) r_cnt_r <= r_cnt_r + CNT_BITS'(1);
                end
                if (n_add[1]) begin
                    r_acc_g <= {r_acc_g[ACC_BITS-5:0], i_tok.digit};
                    if (r_cnt_g != '1) r_cnt_g <= r_cnt_g + CNT_BITS'(1);
                end
                if (n_add[2]) begin
                    r_acc_b <= {r_acc_b[ACC_BITS-5:0], i_tok.digit};
                    if (r_cnt_b != '1) r_cnt_b <= r_cnt_b + CNT_BITS'(1);
                end
            end
            if (o_pop && n_emit) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload; errors report zero components.
    always_ff @(posedge i_clk) begin
        if (o_pop && n_emit) begin
            r_status <= n_status;
            if (n_status == ST_OK) begin
                r_red   <= sc_r[COMP_BITS-1:0];
                r_green <= sc_g[COMP_BITS-1:0];
                r_blue  <= sc_b[COMP_BITS-1:0];
            end else begin
                r_red   <= '0;
                r_green <= '0;
                r_blue  <= '0;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;

endmodule

// ===== rtl/core/rgb_colour_spec_parser_top.sv =====
`timescale 1ns / 1ps
// Top level of the rgb:R/G/B colour spec parser.
// Depends on rgbcsp_pkg, rgbcsp_front, rgbcsp_queue and rgbcsp_back.
//
//  side     handshake            payload
//  -------  -------------------  -----------------------------------------
//  input    i_valid / o_stall    i_ch        one character, 0 ends spec
//  output   o_valid / i_stall    o_status, o_red, o_green, o_blue
//
// One character request per cycle sustained while i_stall does not hold a result. o_valid
// rises once the terminating (or offending) character has been accepted: the token is
// written into the token queue, then the result register loads when the parser pops it;
// a result held by i_stall can delay that pop.
// Reset (synchronous, active low) empties the queue, drops any pending result
// and returns the parser to the start of the prefix.
// o_stall rises only when the two-entry token queue is full, which happens
// when i_stall holds a result while characters keep arriving.
module rgb_colour_spec_parser_top
    import rgbcsp_pkg::*;
#(
    parameter int TARGET_DIGITS = TARGET_DIGITS_DEF,
    parameter int ACC_BITS      = ACC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [CH_BITS-1:0]     i_ch,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [STATUS_BITS-1:0] o_status,
    output logic [COMP_BITS-1:0]   o_red,
    output logic [COMP_BITS-1:0]   o_green,
    output logic [COMP_BITS-1:0]   o_blue
);

    t_token front_tok;
    t_token head_tok;
    logic   q_full;
    logic   q_avail;
    logic   q_pop;

    // Classification is purely a function of the character.
    rgbcsp_front u_front (
        .i_ch  (i_ch),
        .o_tok (front_tok)
    );

    // Decouples input acceptance from a stalled result.
    rgbcsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !q_full),
        .i_tok   (front_tok),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_tok   (head_tok)
    );

    // Parser consumes a token whenever the result register can take a result.
    rgbcsp_back #(
        .TARGET_DIGITS (TARGET_DIGITS),
        .ACC_BITS      (ACC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (q_avail),
        .i_tok    (head_tok),
        .o_pop    (q_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_status (o_status),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue)
    );

    assign o_stall = q_full;

endmodule

// ===== verif/rgbcsp_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for rgb_colour_spec_parser_top: runs its own parser on every
// accepted request and compares each accepted result, in order. Uses rgbcsp_pkg.
module rgbcsp_result_checker
    import rgbcsp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic                   i_req_stall,
    input  logic [CH_BITS-1:0]     i_req_ch,
    input  logic                   i_res_valid,
    input  logic                   i_res_stall,
    input  logic [STATUS_BITS-1:0] i_res_status,
    input  logic [COMP_BITS-1:0]   i_res_red,
    input  logic [COMP_BITS-1:0]   i_res_green,
    input  logic [COMP_BITS-1:0]   i_res_blue,
    output int                     o_mismatches,
    output int                     o_pending
);

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [COMP_BITS-1:0]   red;
        logic [COMP_BITS-1:0]   green;
        logic [COMP_BITS-1:0]   blue;
    } color_result_t;

    typedef enum logic [2:0] {
        PH_PFX0, PH_PFX1, PH_PFX2, PH_PFX3, PH_RED, PH_GREEN, PH_BLUE, PH_SKIP
    } parse_phase_t;

    parse_phase_t              phase;
    logic [ACC_BITS_DEF-1:0]   red_acc, green_acc, blue_acc;
    logic [CNT_BITS-1:0]       red_digits, green_digits, blue_digits;
    color_result_t             pending_colors[$];
    color_result_t             want;
    int                        mismatches = 0;

    function automatic logic [CH_BITS-1:0] prefix_char(parse_phase_t p);
        case (p)
            PH_PFX0: return CH_R;
            PH_PFX1: return CH_G;
            PH_PFX2: return CH_B;
            default: return CH_COLON;
        endcase
    endfunction

    // digit counts stick at 15
    function automatic logic [CNT_BITS-1:0] bump(logic [CNT_BITS-1:0] cnt);
        return (cnt == '1) ? cnt : cnt + 1'b1;
    endfunction

    function automatic logic [COMP_BITS-1:0] scaled_component(
        logic [ACC_BITS_DEF-1:0] acc, int digits);
        int sh;
        if (digits < TARGET_DIGITS_DEF) begin
            sh = 4 * (TARGET_DIGITS_DEF - digits);
            if (sh >= ACC_BITS_DEF) return '0;
            acc = acc << sh;
        end else begin
            sh = 4 * (digits - TARGET_DIGITS_DEF);
            if (sh >= ACC_BITS_DEF) return '0;
            acc = acc >> sh;
        end
        return acc[COMP_BITS-1:0];
    endfunction

    task automatic flag_error(input logic [STATUS_BITS-1:0] st, input logic [CH_BITS-1:0] c);
        pending_colors.push_back('{status: st, red: '0, green: '0, blue: '0});
        // a nonzero offender swallows the rest of the string
        phase = (c == CH_NUL) ? PH_PFX0 : PH_SKIP;
    endtask

    task automatic advance_parser(input logic [CH_BITS-1:0] c);
        logic       is_hex;
        logic [3:0] nib;
        int         widest;
        is_hex = 1'b1;
        nib    = '0;
        if (c >= "0" && c <= "9")      nib = 4'(c - "0");
        else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 10);
        else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 10);
        else                           is_hex = 1'b0;

        case (phase)
            PH_PFX0, PH_PFX1, PH_PFX2, PH_PFX3: begin
                if (c != prefix_char(phase)) begin
                    flag_error(ST_PREFIX, c);
                end else if (phase == PH_PFX3) begin
                    red_acc      = '0;
                    green_acc    = '0;
                    blue_acc     = '0;
                    red_digits   = '0;
                    green_digits = '0;
                    blue_digits  = '0;
                    phase        = PH_RED;
                end else begin
                    phase = parse_phase_t'(phase + 1'b1);
                end
            end
            PH_RED: begin
                if (is_hex) begin
                    red_acc    = {red_acc[ACC_BITS_DEF-5:0], nib};
                    red_digits = bump(red_digits);
                end else if (c == CH_SLASH) begin
                    phase = PH_GREEN;
                end else begin
                    flag_error(ST_RED, c);
                end
            end
            PH_GREEN: begin
                if (is_hex) begin
                    green_acc    = {green_acc[ACC_BITS_DEF-5:0], nib};
                    green_digits = bump(green_digits);
                end else if (c == CH_SLASH) begin
                    phase = PH_BLUE;
                end else begin
                    flag_error(ST_GREEN, c);
                end
            end
            PH_BLUE: begin
                if (is_hex) begin
                    blue_acc    = {blue_acc[ACC_BITS_DEF-5:0], nib};
                    blue_digits = bump(blue_digits);
                end else if (c != CH_NUL) begin
                    flag_error(ST_BLUE, c);
                end else begin
                    widest = red_digits;
                    if (green_digits > widest) widest = green_digits;
                    if (blue_digits > widest)  widest = blue_digits;
                    pending_colors.push_back('{status: ST_OK,
                                               red:    scaled_component(red_acc, widest),
                                               green:  scaled_component(green_acc, widest),
                                               blue:   scaled_component(blue_acc, widest)});
                    phase = PH_PFX0;
                end
            end
            default: begin
                if (c == CH_NUL) phase = PH_PFX0;
            end
        endcase
    endtask

    task automatic compare_field(input string label, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %02h, got %02h", $time, label, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase        = PH_PFX0;
            red_acc      = '0;
            green_acc    = '0;
            blue_acc     = '0;
            red_digits   = '0;
            green_digits = '0;
            blue_digits  = '0;
            pending_colors.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (pending_colors.size() == 0) begin
                    $display("%0t: result with none expected, got status %0d rgb %02h %02h %02h",
                             $time, i_res_status, i_res_red, i_res_green, i_res_blue);
                    mismatches++;
                end else begin
                    want = pending_colors.pop_front();
                    compare_field("status", 8'(want.status), 8'(i_res_status));
                    compare_field("red",    want.red,   i_res_red);
                    compare_field("green",  want.green, i_res_green);
                    compare_field("blue",   want.blue,  i_res_blue);
                end
            end
            if (i_req_valid && !i_req_stall) advance_parser(i_req_ch);
        end
        o_pending    <= pending_colors.size();
        o_mismatches <= mismatches;
    end

endmodule

// ===== verif/rgb_colour_spec_parser_top_test.sv =====
`timescale 1ns / 1ps
// Testbench top for rgb_colour_spec_parser_top: drives character requests,
// stalls the result side and gives the verdict. Uses rgbcsp_pkg and rgbcsp_result_checker.
module rgb_colour_spec_parser_top_test;
    import rgbcsp_pkg::*;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic [CH_BITS-1:0]     i_ch    = '0;
    logic                   i_stall = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic [STATUS_BITS-1:0] o_status;
    logic [COMP_BITS-1:0]   o_red, o_green, o_blue;

    int mismatches;
    int pending;

    // Knobs shared by the sender and receiver processes.
    bit tx_gaps    = 1'b1;   // sender may idle between requests
    bit rx_gaps    = 1'b1;   // receiver may stall between results
    bit jam_now    = 1'b0;   // one-shot request for a long receiver hold-off
    int chars_sent = 0;

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    rgb_colour_spec_parser_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_ch     (i_ch),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_status (o_status),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue)
    );

    rgbcsp_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_req_ch     (i_ch),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_res_status (o_status),
        .i_res_red    (o_red),
        .i_res_green  (o_green),
        .i_res_blue   (o_blue),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Idle length: mostly a few cycles, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [CH_BITS-1:0] random_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return 8'("0" + r);
        if (r < 16) return 8'("a" + r - 10);
        return 8'("A" + r - 16);
    endfunction

    // Mostly short fields; a few long enough to saturate the digit count
    // and push the scaling shift past the accumulator width.
    function automatic int field_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)  return 0;
        if (r < 16) return $urandom_range(1, 4);
        if (r < 19) return $urandom_range(5, 8);
        return $urandom_range(9, 16);
    endfunction

    // One character request. Valid is only dropped when a gap is taken, so
    // back-to-back requests never see a low/high pair in the same step.
    task automatic send_char(input logic [CH_BITS-1:0] c);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 2) == 0) ? idle_length() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    // Random spec: mostly well-formed with random digits, some with one
    // character corrupted, some plain byte noise.
    task automatic send_random_spec();
        logic [CH_BITS-1:0] text[$];
        int                 kind;
        int                 n;
        int                 pos;
        int                 r;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) text.push_back(8'($urandom_range(0, 255)));
            text.push_back(CH_NUL);
        end else begin
            text = '{CH_R, CH_G, CH_B, CH_COLON};
            for (int f = 0; f < 3; f++) begin
                n = field_length();
                repeat (n) text.push_back(random_hex());
                if (f < 2) text.push_back(CH_SLASH);
            end
            text.push_back(CH_NUL);
            if (kind < 3) begin
                pos = $urandom_range(0, text.size() - 1);
                r   = $urandom_range(0, 5);
                if (r == 0)      text[pos] = CH_SLASH;
                else if (r == 1) text[pos] = CH_NUL;
                else             text[pos] = 8'($urandom_range(0, 255));
            end
        end
        foreach (text[i]) send_char(text[i]);
    endtask

    // Receiver: random stalls, stretches without any, and a hold-off
    // on request (jam_now) so the token queue fills and o_stall rises.
    initial begin
        int hold;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 199) == 0) rx_gaps = !rx_gaps;
            if (jam_now) begin
                jam_now = 1'b0;
                hold    = 80;
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                hold = idle_length();
            end else begin
                hold = 0;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold - 1) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int random_start;
        int spec_no;
        int waited;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed specs.
        send_str("rgb://");                     // all fields empty
        send_char(CH_NUL);
        send_str("rgb:F/e/D");                  // one digit each, scaled up
        send_char(CH_NUL);
        send_str("rgb:0123456789abcdefAB/1/ff"); // count saturates, shift too wide
        send_char(CH_NUL);
        send_str("rgb:123/4567/89abc");         // widest field five digits
        send_char(CH_NUL);
        send_char(8'hFF);                       // bad prefix on an all-ones byte,
        send_str("rgb:");                       // rest swallowed up to terminator
        send_char(CH_NUL);
        send_char(CH_NUL);                      // bad prefix at the terminator
        send_str("rgbr");                       // bad last prefix character
        send_char(CH_NUL);
        send_str("rgb:1g");                     // bad character in red
        send_char(CH_NUL);
        send_str("rgb:7");                      // red ends at terminator
        send_char(CH_NUL);
        send_str("rgb:2/3x");                   // bad character in green
        send_char(CH_NUL);
        send_str("rgb:/");                      // green ends at terminator
        send_char(CH_NUL);
        send_str("rgb:a/b/c/9");                // separator inside blue
        send_char(CH_NUL);
        send_str("rgb:1/2/3?");                 // bad character in blue
        send_char(CH_NUL);

        // Random specs; sender idling toggles in stretches, and now and then
        // the receiver is asked to hold off while the sender runs flat out.
        random_start = chars_sent;
        spec_no      = 0;
        while (chars_sent - random_start < 1050) begin
            if (spec_no % 10 == 0) tx_gaps = ($urandom_range(0, 3) != 0);
            if (spec_no % 45 == 7) begin
                tx_gaps = 1'b0;
                jam_now = 1'b1;
            end
            send_random_spec();
            spec_no++;
        end
        i_valid <= 1'b0;
        tx_gaps  = 1'b1;

        // Drain: let the checker count the last request, wait for outstanding
        // results, then a few cycles for strays.
        @(posedge i_clk);
        waited = 0;
        while (pending != 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);

        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #6ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rgbcsp_pkg.sv
rtl/core/rgbcsp_front.sv
rtl/core/rgbcsp_queue.sv
rtl/core/rgbcsp_back.sv
rtl/core/rgb_colour_spec_parser_top.sv
verif/rgbcsp_result_checker.sv
verif/rgb_colour_spec_parser_top_test.sv
